// ----- hw/rtl/irt_pkg.sv -----
// irt_pkg: types and constants shared by the ipv6 reassembly tracker modules
// no dependencies

package irt_pkg;

    localparam int unsigned SLOT_W = 3;

    typedef struct packed {
        logic        func;
        logic [31:0] now_ms;
        logic [31:0] ident;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [12:0] frag_units;
        logic        more_flag;
        logic [15:0] payload_len;
        logic [15:0] unfrag_len;
        logic [7:0]  next_hdr;
    } irt_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  slot;
        logic [16:0] write_offset;
        logic [15:0] write_length;
        logic [15:0] datagram_payload_len;
        logic [7:0]  out_next_hdr;
        logic        last;
    } irt_out_t;

    typedef enum logic [2:0] {
        ST_UNFRAG   = 3'd0,
        ST_STORED   = 3'd1,
        ST_COMPLETE = 3'd2,
        ST_DUP      = 3'd3,
        ST_GAP      = 3'd4,
        ST_TOOBIG   = 3'd5,
        ST_NOSLOT   = 3'd6,
        ST_TIMEOUT  = 3'd7
    } irt_status_t;

    typedef enum logic [1:0] {
        CFG_TIMEOUT = 2'd0,
        CFG_MAXLEN  = 2'd1
    } irt_cfg_idx_t;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_SCAN  = 2'd1,
        BK_EMIT  = 2'd2
    } irt_bk_state_t;

    // classified item handed from front to back
    typedef struct packed {
        irt_in_t     item;
        logic        unfrag;
        logic [17:0] total;
        logic [16:0] off;
        logic [16:0] frag_end;
    } irt_cmd_t;

endpackage

// ----- hw/rtl/irt_front.sv -----
// irt_front: input stage, classifies items and precomputes lengths
// depends on irt_pkg

module irt_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  irt_pkg::irt_in_t  s_data,
    output logic              q_valid,
    input  logic              q_ready,
    output irt_pkg::irt_cmd_t q_cmd
);
    import irt_pkg::*;

    // two-entry queue toward the back end
    irt_cmd_t   mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    irt_cmd_t   cmd;
    logic       push, pop;

    always_comb begin
        cmd.item     = s_data;
        cmd.unfrag   = (s_data.frag_units == 13'd0) && !s_data.more_flag;
        cmd.off      = {1'b0, s_data.frag_units, 3'b000};
        cmd.frag_end = cmd.off + {1'b0, s_data.payload_len};
        cmd.total    = {1'b0, cmd.frag_end} + {2'b00, s_data.unfrag_len};
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_cmd   = mem_reg[rp_reg];

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= cmd;
        end
    end

endmodule

// ----- hw/rtl/irt_back.sv -----
// irt_back: slot table, one slot compared per cycle while no expiry result waits on a busy output, result generation
// depends on irt_pkg

module irt_back #(
    parameter int unsigned NUM_SLOTS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  irt_pkg::irt_cmd_t q_cmd,
    input  logic [31:0]       timeout_ms,
    input  logic [15:0]       max_len,
    output logic              m_valid,
    input  logic              m_ready,
    output irt_pkg::irt_out_t m_data
);
    import irt_pkg::*;

    localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
    localparam int unsigned MAX_OUT = 8;

    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [31:0]  s_ident  [NUM_SLOTS];
    logic [63:0]  s_shi    [NUM_SLOTS];
    logic [63:0]  s_slo    [NUM_SLOTS];
    logic [63:0]  s_dhi    [NUM_SLOTS];
    logic [63:0]  s_dlo    [NUM_SLOTS];
    logic [31:0]  s_start  [NUM_SLOTS];
    logic [16:0]  s_nxt    [NUM_SLOTS];
    logic [16:0]  s_len    [NUM_SLOTS];

    irt_bk_state_t st_reg, st_next;
    irt_cmd_t      cmd_reg;
    logic [CW-1:0] idx_reg, idx_next;
    logic          hit_reg, hit_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic          fr_reg, fr_next;
    logic [IW-1:0] fr_idx_reg, fr_idx_next;
    logic [3:0]    nexp_reg, nexp_next;

    irt_out_t      out_reg, out_next;
    logic          ov_reg, ov_next;
    // pending expiry result, emitted when the next one is found or scan ends
    irt_out_t      pend_reg, pend_next;
    logic          pv_reg, pv_next;

    logic [IW-1:0] cur;
    logic          scan_done, out_free, cur_match, cur_exp;
    logic [31:0]   age;

    logic          wr_alloc, wr_upd;
    logic [IW-1:0] wr_idx;
    logic [16:0]   new_len, new_nxt;

    assign cur       = idx_reg[IW-1:0];
    assign scan_done = (idx_reg == CW'(NUM_SLOTS));
    assign out_free  = !ov_reg || m_ready;
    assign q_ready   = (st_reg == BK_IDLE);
    assign m_valid   = ov_reg;
    assign m_data    = out_reg;
    assign age       = cmd_reg.item.now_ms - s_start[cur];
    assign cur_match = valid_reg[cur] && s_ident[cur] == cmd_reg.item.ident
                       && s_shi[cur] == cmd_reg.item.src_hi
                       && s_slo[cur] == cmd_reg.item.src_lo
                       && s_dhi[cur] == cmd_reg.item.dst_hi
                       && s_dlo[cur] == cmd_reg.item.dst_lo;
    assign cur_exp   = valid_reg[cur] && (age >= timeout_ms);

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    st_next = BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (cmd_reg.item.func) begin
                    if (out_free && (scan_done || nexp_reg == 4'(MAX_OUT))) begin
                        st_next = BK_IDLE;
                    end
                end else if (cmd_reg.unfrag || scan_done) begin
                    st_next = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (out_free) begin
                    st_next = BK_IDLE;
                end
            end
            default: st_next = BK_IDLE;
        endcase
    end

    always_comb begin
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        fr_next      = fr_reg;
        fr_idx_next  = fr_idx_reg;
        nexp_next    = nexp_reg;
        valid_next   = valid_reg;
        out_next     = out_reg;
        ov_next      = ov_reg && !m_ready;
        pend_next    = pend_reg;
        pv_next      = pv_reg;
        wr_alloc     = 1'b0;
        wr_upd       = 1'b0;
        wr_idx       = hit_idx_reg;
        new_len      = '0;
        new_nxt      = '0;
        unique case (st_reg)
            BK_IDLE: begin
                idx_next  = '0;
                hit_next  = 1'b0;
                fr_next   = 1'b0;
                nexp_next = '0;
                pv_next   = 1'b0;
            end
            BK_SCAN: begin
                if (cmd_reg.item.func) begin
                    if (scan_done || nexp_reg == 4'(MAX_OUT)) begin
                        if (out_free && pv_reg) begin
                            out_next      = pend_reg;
                            out_next.last = 1'b1;
                            ov_next       = 1'b1;
                            pv_next       = 1'b0;
                        end
                    end else if (out_free || !pv_reg) begin
                        if (cur_exp) begin
                            valid_next[cur] = 1'b0;
                            if (pv_reg) begin
                                out_next = pend_reg;
                                ov_next  = 1'b1;
                            end
                            pend_next = '0;
                            pend_next.status = ST_TIMEOUT;
                            pend_next.slot   = 3'(cur);
                            pv_next   = 1'b1;
                            nexp_next = nexp_reg + 4'd1;
                        end
                        idx_next = idx_reg + CW'(1);
                    end
                end else if (!cmd_reg.unfrag && !scan_done) begin
                    if (cur_match && !hit_reg) begin
                        hit_next     = 1'b1;
                        hit_idx_next = cur;
                    end
                    if (!valid_reg[cur] && !fr_reg) begin
                        fr_next     = 1'b1;
                        fr_idx_next = cur;
                    end
                    idx_next = idx_reg + CW'(1);
                end
            end
            BK_EMIT: begin
                if (out_free) begin
                    ov_next  = 1'b1;
                    out_next = '0;
                    out_next.last = 1'b1;
                    if (cmd_reg.unfrag) begin
                        out_next.status = ST_UNFRAG;
                    end else if (cmd_reg.total > {2'b00, max_len}) begin
                        out_next.status = ST_TOOBIG;
                        if (hit_reg) begin
                            out_next.slot = 3'(hit_idx_reg);
                            valid_next[hit_idx_reg] = 1'b0;
                        end
                    end else if (!hit_reg && !fr_reg) begin
                        out_next.status = ST_NOSLOT;
                    end else if (hit_reg && cmd_reg.off < s_nxt[hit_idx_reg]) begin
                        out_next.status = ST_DUP;
                        out_next.slot   = 3'(hit_idx_reg);
                    end else if (hit_reg && cmd_reg.off > s_nxt[hit_idx_reg]) begin
                        out_next.status = ST_GAP;
                        out_next.slot   = 3'(hit_idx_reg);
                        valid_next[hit_idx_reg] = 1'b0;
                    end else begin
                        // accepted: new slot starts at offset 0, length unfrag_len; both raised to frag_end, total
                        wr_idx   = hit_reg ? hit_idx_reg : fr_idx_reg;
                        wr_alloc = !hit_reg;
                        wr_upd   = 1'b1;
                        new_len  = hit_reg ? s_len[hit_idx_reg]
                                           : {1'b0, cmd_reg.item.unfrag_len};
                        new_nxt  = hit_reg ? s_nxt[hit_idx_reg] : 17'd0;
                        if ({1'b0, new_len} < cmd_reg.total) begin
                            new_len = cmd_reg.total[16:0];
                        end
                        if (cmd_reg.frag_end > new_nxt) begin
                            new_nxt = cmd_reg.frag_end;
                        end
                        out_next.slot         = 3'(wr_idx);
                        out_next.write_offset = 17'(cmd_reg.item.unfrag_len) + cmd_reg.off;
                        out_next.write_length = cmd_reg.item.payload_len;
                        if (cmd_reg.item.more_flag) begin
                            out_next.status = ST_STORED;
                            valid_next[wr_idx] = 1'b1;
                        end else begin
                            out_next.status = ST_COMPLETE;
                            valid_next[wr_idx] = 1'b0;
                            out_next.datagram_payload_len =
                                (new_len >= 17'd40) ? 16'(new_len - 17'd40) : 16'd0;
                            out_next.out_next_hdr = cmd_reg.item.next_hdr;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= BK_IDLE;
            valid_reg <= '0;
            ov_reg    <= 1'b0;
            pv_reg    <= 1'b0;
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
            fr_reg    <= 1'b0;
            nexp_reg  <= '0;
        end else begin
            st_reg    <= st_next;
            valid_reg <= valid_next;
            ov_reg    <= ov_next;
            pv_reg    <= pv_next;
            idx_reg   <= idx_next;
            hit_reg   <= hit_next;
            fr_reg    <= fr_next;
            nexp_reg  <= nexp_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_idx_reg <= hit_idx_next;
        fr_idx_reg  <= fr_idx_next;
        out_reg     <= out_next;
        pend_reg    <= pend_next;
        if (st_reg == BK_IDLE && q_valid) begin
            cmd_reg <= q_cmd;
        end
        if (wr_upd) begin
            s_len[wr_idx] <= new_len;
            s_nxt[wr_idx] <= new_nxt;
        end
        if (wr_alloc) begin
            s_ident[wr_idx] <= cmd_reg.item.ident;
            s_shi[wr_idx]   <= cmd_reg.item.src_hi;
            s_slo[wr_idx]   <= cmd_reg.item.src_lo;
            s_dhi[wr_idx]   <= cmd_reg.item.dst_hi;
            s_dlo[wr_idx]   <= cmd_reg.item.dst_lo;
            s_start[wr_idx] <= cmd_reg.item.now_ms;
        end
    end

endmodule

// ----- hw/rtl/ipv6_reassembly_tracker_unit.sv -----
// Ipv6 fragment reassembly tracker: a front stage takes and classifies items into a
// two-entry queue; a back end walks the slot table one slot per cycle, skipping it for
// unfragmented items, and a tick's walk holds while an expiry result waits on a busy
// output and stops after MAX_OUT expiries; the slot walk sets the rate. Results leave
// through a register. Depends on irt_pkg, irt_front, irt_back.

module ipv6_reassembly_tracker_unit #(
    parameter int unsigned NUM_SLOTS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  irt_pkg::irt_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output irt_pkg::irt_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import irt_pkg::*;

    logic        q_valid, q_ready;
    irt_cmd_t    q_cmd;
    logic [31:0] timeout_reg;
    logic [15:0] maxlen_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= 32'd60000;
            maxlen_reg  <= 16'd1280;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TIMEOUT: timeout_reg <= cfg_data;
                CFG_MAXLEN:  maxlen_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    irt_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd)
    );

    irt_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_cmd      (q_cmd),
        .timeout_ms (timeout_reg),
        .max_len    (maxlen_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
